>>> design/srlr_pkg.sv
// package for the stamp rotation line renderer
// holds shared types, codes and the rotation flip tables; no dependencies
package srlr_pkg;

	localparam int ADDR_W = 18;

	typedef enum logic [2:0] {
		CMD_START_JOB  = 3'd0,
		CMD_START_LINE = 3'd1,
		CMD_STAMP      = 3'd2,
		CMD_SOURCE     = 3'd3,
		CMD_DEST       = 3'd4
	} cmd_t;

	typedef enum logic [2:0] {
		REQ_STAMP  = 3'd0,
		REQ_SOURCE = 3'd1,
		REQ_DREAD  = 3'd2,
		REQ_DWRITE = 3'd3,
		REQ_DONE   = 3'd4
	} req_t;

	typedef enum logic [2:0] {
		REG_MODE   = 3'd0,
		REG_STAMP  = 3'd1,
		REG_IMAGE  = 3'd2,
		REG_VCELL  = 3'd3,
		REG_OFFSET = 3'd4,
		REG_HDOTS  = 3'd5
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK,
		ST_WAIT_STAMP,
		ST_WAIT_SOURCE,
		ST_WAIT_DEST,
		ST_OUT
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic start_job;
		logic start_line;
		logic load_stamp;
		logic load_source;
		logic load_dest;
		logic advance;
		logic emit_stamp;
		logic emit_pixel;
		logic emit_done;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic dots_zero;
		logic out_of_map;
		logic prio_zero;
		logic pix_zero;
		logic write_ok;
		logic stamp_zero;
	} dp_stat_t;

	typedef struct packed {
		logic [2:0]        request;
		logic [ADDR_W-1:0] address;
		logic [7:0]        write_data;
		logic              last;
	} res_t;

	function automatic logic col_flip(input logic [2:0] s);
		logic [7:0] t;
		t = 8'b0011_0110;
		return t[s];
	endfunction

	function automatic logic row_flip(input logic [2:0] s);
		logic [7:0] t;
		t = 8'b0110_1100;
		return t[s];
	endfunction

endpackage

>>> design/srlr_if.sv
// valid/ready channel interfaces for the renderer
// depends on srlr_pkg for the address width
interface srlr_in_if;
	logic        valid;
	logic        ready;
	logic [2:0]  command;
	logic [15:0] start_x;
	logic [15:0] start_y;
	logic signed [15:0] step_x_in;
	logic signed [15:0] step_y_in;
	logic [15:0] reply_data;
	modport source(output valid, command, start_x, start_y, step_x_in, step_y_in,
		reply_data, input ready);
	modport sink(input valid, command, start_x, start_y, step_x_in, step_y_in,
		reply_data, output ready);
endinterface

interface srlr_out_if import srlr_pkg::*;;
	logic              valid;
	logic              ready;
	logic [2:0]        request;
	logic [ADDR_W-1:0] address;
	logic [7:0]        write_data;
	logic              last;
	modport source(output valid, request, address, write_data, last, input ready);
	modport sink(input valid, request, address, write_data, last, output ready);
endinterface

>>> design/srlr_datapath.sv
// datapath: config registers, position walk, address and pixel logic
// depends on srlr_pkg
module srlr_datapath import srlr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	input  dp_cmd_t     cmd,
	input  logic [15:0] start_x,
	input  logic [15:0] start_y,
	input  logic [15:0] step_x,
	input  logic [15:0] step_y,
	input  logic [15:0] reply,
	output dp_stat_t    stat,
	output res_t        res
);
	logic [4:0]  mode_q;
	logic [15:0] smap_reg_q, ibuf_reg_q;
	logic [4:0]  vcell_q;
	logic [5:0]  ioff_q;
	logic [8:0]  hdots_q;

	logic [23:0] xpos_q, ypos_q;
	logic [15:0] xstep_q, ystep_q;
	logic [2:0]  col_q;
	logic [17:0] dbase_q, sbase_q;
	logic [7:0]  loff_q;
	logic [8:0]  dots_q;
	logic [3:0]  pix_q;
	logic        nlow_q;

	logic [23:0] mmask;
	logic [15:0] idx;
	logic [17:0] stamp_addr, dest_addr;
	logic [16:0] dsum;
	logic [2:0]  sel;
	logic [23:0] u, v;
	logic [6:0]  mr, row;
	logic [8:0]  cf, col;
	logic [13:0] nib;
	logic [3:0]  spix;
	logic        under;
	logic [7:0]  merged;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= '0; smap_reg_q <= '0; ibuf_reg_q <= '0;
			vcell_q <= '0; ioff_q <= '0; hdots_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_MODE:   mode_q     <= cfg_data[4:0];
				REG_STAMP:  smap_reg_q <= cfg_data;
				REG_IMAGE:  ibuf_reg_q <= cfg_data;
				REG_VCELL:  vcell_q    <= cfg_data[4:0];
				REG_OFFSET: ioff_q     <= cfg_data[5:0];
				REG_HDOTS:  hdots_q    <= cfg_data[8:0];
				default: ;
			endcase
		end
	end

	assign mmask = mode_q[2] ? 24'h800000 : 24'hf80000;
	always_comb begin
		case (mode_q[2:1])
			2'b01:   idx = {10'd0, ypos_q[18:16], xpos_q[18:16]};
			2'b11:   idx = {2'd0, ypos_q[22:16], xpos_q[22:16]};
			2'b00:   idx = {8'd0, ypos_q[18:15], xpos_q[18:15]};
			default: idx = {ypos_q[22:15], xpos_q[22:15]};
		endcase
	end
	assign stamp_addr = sbase_q + {1'b0, idx, 1'b0};
	assign dest_addr  = dbase_q + {16'd0, col_q[2:1] ^ 2'b01};
	assign dsum       = {1'b0, ibuf_reg_q & 16'hfff8} + {9'd0, loff_q};

	// stamp word decode: rotation and flip
	always_comb begin
		sel = {reply[15], reply[14:13]};
		mr  = mode_q[1] ? 7'h7c : 7'h3c;
		cf  = mode_q[1] ? 9'h180 : 9'h040;
		u   = sel[0] ? ypos_q : xpos_q;
		v   = sel[0] ? xpos_q : ypos_q;
		row = v[15:9] & mr;
		if (row_flip(sel)) row = row ^ mr;
		col = mode_q[1] ? (u[15:7] & 9'h180) : ({1'b0, u[15:8]} & 9'h040);
		if (col_flip(sel)) begin
			col = col ^ cf;
			nib = u[13:0] & 14'h3800 ^ 14'h2800;
		end else begin
			nib = u[13:0] & 14'h3800 ^ 14'h1000;
		end
	end

	assign spix   = nlow_q ? reply[3:0] : reply[7:4];
	assign under  = mode_q[4:3] == 2'b01;
	assign merged = col_q[0] ? {reply[7:4], pix_q} : {pix_q, reply[3:0]};

	assign stat.dots_zero  = dots_q == '0;
	assign stat.out_of_map = !mode_q[0] && (((xpos_q | ypos_q) & mmask) != '0);
	assign stat.prio_zero  = mode_q[4:3] == 2'b00;
	assign stat.pix_zero   = pix_q == '0;
	assign stat.write_ok   = col_q[0] ? !(reply[3:0] != '0 && under)
		: !(reply[7:4] != '0 && under);
	assign stat.stamp_zero = reply[10:0] == '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xpos_q <= '0; ypos_q <= '0; xstep_q <= '0; ystep_q <= '0;
			col_q <= '0; dbase_q <= '0; loff_q <= '0; dots_q <= '0;
			pix_q <= '0; nlow_q <= '0; sbase_q <= '0;
		end else begin
			if (cmd.start_job) begin
				loff_q <= {5'd0, ioff_q[5:3]};
				case (mode_q[2:1])
					2'b00:   sbase_q <= {smap_reg_q & 16'hff80, 2'b00};
					2'b01:   sbase_q <= {smap_reg_q & 16'hffe0, 2'b00};
					2'b10:   sbase_q <= 18'h20000;
					default: sbase_q <= {smap_reg_q & 16'he000, 2'b00};
				endcase
			end
			if (cmd.start_line) begin
				xpos_q  <= {start_x, 8'd0};
				ypos_q  <= {start_y, 8'd0};
				xstep_q <= step_x;
				ystep_q <= step_y;
				col_q   <= ioff_q[2:0];
				dbase_q <= {dsum[15:0], 2'b00};
				dots_q  <= hdots_q;
			end
			if (cmd.load_stamp) begin
				// zero stamp number gives pixel zero
				if (reply[10:0] == '0) begin
					pix_q <= '0;
				end else begin
					nlow_q <= nib[11];
				end
			end
			if (cmd.load_source) pix_q <= spix;
			if (cmd.emit_stamp && stat.out_of_map) pix_q <= '0;
			if (cmd.advance) begin
				xpos_q <= xpos_q + {{8{xstep_q[15]}}, xstep_q};
				ypos_q <= ypos_q + {{8{ystep_q[15]}}, ystep_q};
				col_q  <= col_q + 3'd1;
				if (col_q == 3'd7)
					dbase_q <= dbase_q + {7'd0, {1'b0, vcell_q} + 6'd1, 5'd0};
				dots_q <= dots_q - 9'd1;
			end
			if (cmd.emit_done) loff_q <= loff_q + 8'd1;
		end
	end

	// result assembly from the emit and load commands
	always_comb begin
		res = '0;
		if (cmd.emit_done) begin
			res.request = REQ_DONE;
		end else if (cmd.emit_pixel) begin
			res.request = REQ_DREAD;
			res.address = dest_addr;
		end else if (cmd.emit_stamp) begin
			res.request = REQ_STAMP;
			res.address = stamp_addr;
		end else if (cmd.load_stamp) begin
			res.request = REQ_SOURCE;
			res.address = {reply[10:0], 7'd0} + {11'd0, row} + {9'd0, col}
				+ {16'd0, nib[13:12]};
		end else if (cmd.load_dest) begin
			res.request    = REQ_DWRITE;
			res.address    = dest_addr;
			res.write_data = merged;
		end
	end
endmodule

>>> design/srlr_ctrl.sv
// controller state machine: sequences dot walk, replies and output staging
// depends on srlr_pkg
module srlr_ctrl import srlr_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] command,
	input  logic       out_busy,
	input  dp_stat_t   stat,
	output dp_cmd_t    cmd,
	output logic       emit,
	output state_t     state
);
	state_t state_q, state_d;
	logic   acc;
	logic   walking;

	assign state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	// inputs are taken when not walking and output slot is free
	assign walking  = state_q == ST_WALK || state_q == ST_OUT;
	assign in_ready = !walking && !out_busy;
	assign acc      = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		emit    = 1'b0;
		case (state_q)
			ST_WALK, ST_OUT: begin
				// a pixel is ready in ST_OUT: zero pixels are skipped unless overwriting
				if (!out_busy) begin
					if (state_q == ST_OUT) begin
						if (stat.pix_zero && !stat.prio_zero) begin
							cmd.advance = 1'b1;
							state_d = ST_WALK;
						end else begin
							cmd.emit_pixel = 1'b1;
							emit = 1'b1;
							state_d = ST_WAIT_DEST;
						end
					end else if (stat.dots_zero) begin
						cmd.emit_done = 1'b1;
						emit = 1'b1;
						state_d = ST_IDLE;
					end else if (stat.out_of_map) begin
						if (stat.prio_zero) begin
							cmd.emit_stamp = 1'b1;
							state_d = ST_OUT;
						end else begin
							cmd.advance = 1'b1;
						end
					end else begin
						cmd.emit_stamp = 1'b1;
						emit = 1'b1;
						state_d = ST_WAIT_STAMP;
					end
				end
			end
			default: begin
				if (acc) begin
					case (command)
						CMD_START_JOB: begin
							cmd.start_job = 1'b1;
							state_d = ST_IDLE;
						end
						CMD_START_LINE: begin
							cmd.start_line = 1'b1;
							state_d = ST_WALK;
						end
						CMD_STAMP: if (state_q == ST_WAIT_STAMP) begin
							cmd.load_stamp = 1'b1;
							if (stat.stamp_zero) begin
								state_d = ST_OUT;
							end else begin
								emit = 1'b1;
								state_d = ST_WAIT_SOURCE;
							end
						end
						CMD_SOURCE: if (state_q == ST_WAIT_SOURCE) begin
							cmd.load_source = 1'b1;
							state_d = ST_OUT;
						end
						CMD_DEST: if (state_q == ST_WAIT_DEST) begin
							cmd.load_dest = 1'b1;
							cmd.advance   = 1'b1;
							emit = stat.write_ok;
							state_d = ST_WALK;
						end
						default: ;
					endcase
				end
			end
		endcase
	end
endmodule

>>> design/stamp_rotation_line_renderer_unit.sv
// top level of the stamp rotation line renderer; depends on srlr_pkg, srlr_if,
// srlr_ctrl and srlr_datapath. Items are taken one at a time: a result is staged in a
// single output register, so the input is held off while the block walks dots and
// while a result waits for the receiver. A start line item gives its first request
// once the walk reaches a dot to draw; a dot off the map is skipped under a nonzero
// priority, or drawn as zero otherwise. A stamp reply gives its source read; a zero
// stamp number and a source reply lead on to the destination read, unless the dot is
// skipped. A destination reply gives its write, unless the priority keeps a nonzero
// destination pixel, and the walk goes on to the next request of the line when the
// receiver takes the write.
module stamp_rotation_line_renderer_unit import srlr_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data,
	srlr_in_if.sink     in_ch,
	srlr_out_if.source  out_ch
);
	dp_cmd_t  cmd;
	dp_stat_t stat;
	res_t     res;
	state_t   state;
	logic     emit;
	logic     pend_q;
	res_t     out_q;

	// the stamp reply result and dest write are produced on the input edge
	srlr_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(in_ch.valid), .in_ready(in_ch.ready), .command(in_ch.command),
		.out_busy(pend_q && !out_ch.ready), .stat, .cmd, .emit, .state
	);

	srlr_datapath u_dp (
		.clk, .arst_n, .cfg_we, .cfg_index, .cfg_data, .cmd,
		.start_x(in_ch.start_x), .start_y(in_ch.start_y),
		.step_x(in_ch.step_x_in), .step_y(in_ch.step_y_in),
		.reply(in_ch.reply_data), .stat, .res
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 1'b0;
			out_q  <= '0;
		end else begin
			if (emit) pend_q <= 1'b1;
			else if (out_ch.ready) pend_q <= 1'b0;
			// a dest write is followed by walk output, so it is not last then
			if (emit)
				out_q <= {res.request, res.address, res.write_data, !cmd.load_dest};
		end
	end

	assign out_ch.valid      = pend_q;
	assign out_ch.request    = out_q.request;
	assign out_ch.address    = out_q.address;
	assign out_ch.write_data = out_q.write_data;
	assign out_ch.last       = out_q.last;

	a_state_ok: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.ready |-> !(state == ST_WALK || state == ST_OUT))
		else $error("input taken while walking");
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && !out_ch.ready) |=> out_ch.valid)
		else $error("result dropped");
endmodule
